// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files. Every check is sampled on the rising
// edge of clk and is switched off while reset is active.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ICCA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ICCA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ICCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/icca_pkg.sv =====
`default_nettype none
package icca_pkg;

  localparam int SYM_W    = 4;
  localparam int CNT_W    = 8;
  localparam int IDX_W    = 10;
  localparam int WEIGHT_W = 64;
  localparam int CFG_W    = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [0:0] {
    CFG_NUM_COLORS = 1'b0,
    CFG_LEVEL      = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] NUM_COLORS_RST = 4'd2;
  localparam logic [CFG_W-1:0] LEVEL_RST      = 4'd1;

  // One finished word pair on its way to the count store.
  typedef struct packed {
    logic                ok;
    logic                in_range;
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] weight;
  } job_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/interlacing_check_count_accumulator_top.sv =====
`default_nettype none
// A result passes through the job queue, the store read stage and the output register
// on its way to out_valid. Throughput: one item per cycle while in_stall is low; the count
// store read-modify-write forwards between consecutive pairs, so pairs hitting the same
// index also run back to back. Reset (synchronous, rst_n low) clears counters and queue,
// then a clearing pass zeroes every count store entry while in_stall is held high.
module interlacing_check_count_accumulator_top #(
  parameter int MAX_COLORS   = 8,
  parameter int MAX_LEVEL    = 15,
  parameter int TARGET_DEPTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [icca_pkg::CFG_W-1:0]        cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [icca_pkg::SYM_W-1:0]        in_upper_color,
  input  wire logic [icca_pkg::SYM_W-1:0]        in_lower_color,
  input  wire logic                              in_lower_present,
  input  wire logic                              in_last,
  input  wire logic [icca_pkg::IDX_W-1:0]        in_target_index,
  input  wire logic [icca_pkg::WEIGHT_W-1:0]     in_weight,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_interlaced,
  output logic [icca_pkg::WEIGHT_W-1:0]          out_target_total
);

  icca_pkg::job_t push_job;
  icca_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  logic           store_busy;

  icca_front #(
    .MAX_COLORS  (MAX_COLORS),
    .MAX_LEVEL   (MAX_LEVEL),
    .TARGET_DEPTH(TARGET_DEPTH)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_upper_color  (in_upper_color),
    .in_lower_color  (in_lower_color),
    .in_lower_present(in_lower_present),
    .in_last         (in_last),
    .in_target_index (in_target_index),
    .in_weight       (in_weight),
    .q_full          (q_full),
    .store_busy      (store_busy),
    .push            (push),
    .push_job        (push_job)
  );

  icca_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head_job(head_job),
    .empty   (q_empty),
    .full    (q_full)
  );

  icca_back #(
    .TARGET_DEPTH(TARGET_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .q_empty         (q_empty),
    .pop             (pop),
    .store_busy      (store_busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_interlaced  (out_interlaced),
    .out_target_total(out_target_total)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/icca_front.sv =====
`default_nettype none
module icca_front #(
  parameter int MAX_COLORS   = 8,
  parameter int MAX_LEVEL    = 15,
  parameter int TARGET_DEPTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [icca_pkg::CFG_W-1:0]           cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [icca_pkg::SYM_W-1:0]           in_upper_color,
  input  wire logic [icca_pkg::SYM_W-1:0]           in_lower_color,
  input  wire logic                                 in_lower_present,
  input  wire logic                                 in_last,
  input  wire logic [icca_pkg::IDX_W-1:0]           in_target_index,
  input  wire logic [icca_pkg::WEIGHT_W-1:0]        in_weight,
  input  wire logic                                 q_full,
  input  wire logic                                 store_busy,
  output logic                                      push,
  output icca_pkg::job_t                            push_job
);

  logic [icca_pkg::CFG_W-1:0] num_colors_r;
  logic [icca_pkg::CFG_W-1:0] level_r;

  logic [icca_pkg::CNT_W-1:0] up_cnt_r  [MAX_COLORS];
  logic [icca_pkg::CNT_W-1:0] lo_cnt_r  [MAX_COLORS];
  logic [icca_pkg::CNT_W-1:0] up_cnt_nxt[MAX_COLORS];
  logic [icca_pkg::CNT_W-1:0] lo_cnt_nxt[MAX_COLORS];
  logic                       failed_r;
  logic                       failed_nxt;

  logic                       accept;
  logic [4:0]                 n_eff;
  logic [icca_pkg::CNT_W-1:0] lv;
  logic [icca_pkg::CNT_W-1:0] lv_up;
  logic                       counts_ok;
  logic [31:0]                idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_colors_r <= icca_pkg::NUM_COLORS_RST;
      level_r      <= icca_pkg::LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        icca_pkg::CFG_NUM_COLORS: num_colors_r <= cfg_wdata;
        icca_pkg::CFG_LEVEL:      level_r      <= cfg_wdata;
      endcase
    end
  end

  assign in_stall = q_full | store_busy;
  assign accept   = in_valid & ~in_stall;
  assign push     = accept & in_last;

  assign n_eff = ({1'b0, num_colors_r} > 5'(MAX_COLORS)) ? 5'(MAX_COLORS)
                                                         : {1'b0, num_colors_r};
  assign lv    = ({4'b0, level_r} > 8'(MAX_LEVEL)) ? 8'(MAX_LEVEL) : {4'b0, level_r};
  assign lv_up = lv + 8'd1;

  // Each color lane checks its own counters; the upper symbol is applied first,
  // so the lower check compares against the already updated upper count.
  always_comb begin
    failed_nxt = failed_r;
    counts_ok  = 1'b1;
    for (int k = 0; k < MAX_COLORS; k++) begin
      up_cnt_nxt[k] = up_cnt_r[k];
      lo_cnt_nxt[k] = lo_cnt_r[k];
      if (5'(k) < n_eff) begin
        if ({1'b0, in_upper_color} == 5'(k + 1)) begin
          if (up_cnt_r[k] != lo_cnt_r[k]) begin
            failed_nxt = 1'b1;
          end
          up_cnt_nxt[k] = icca_pkg::sat_inc(up_cnt_r[k]);
        end
        if (in_lower_present && ({1'b0, in_lower_color} == 5'(k + 1))) begin
          if (({1'b0, lo_cnt_r[k]} + 9'd1) != {1'b0, up_cnt_nxt[k]}) begin
            failed_nxt = 1'b1;
          end
          lo_cnt_nxt[k] = icca_pkg::sat_inc(lo_cnt_r[k]);
        end
        if ((lo_cnt_nxt[k] != lv) || (up_cnt_nxt[k] != lv_up)) begin
          counts_ok = 1'b0;
        end
      end
    end
  end

  assign idx_ext           = {{(32 - icca_pkg::IDX_W){1'b0}}, in_target_index};
  assign push_job.ok       = ~failed_nxt & counts_ok;
  assign push_job.in_range = idx_ext < 32'(TARGET_DEPTH);
  assign push_job.idx      = in_target_index;
  assign push_job.weight   = in_weight;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      failed_r <= 1'b0;
      for (int k = 0; k < MAX_COLORS; k++) begin
        up_cnt_r[k] <= '0;
        lo_cnt_r[k] <= '0;
      end
    end else if (accept) begin
      if (in_last) begin
        failed_r <= 1'b0;
        for (int k = 0; k < MAX_COLORS; k++) begin
          up_cnt_r[k] <= '0;
          lo_cnt_r[k] <= '0;
        end
      end else begin
        failed_r <= failed_nxt;
        for (int k = 0; k < MAX_COLORS; k++) begin
          up_cnt_r[k] <= up_cnt_nxt[k];
          lo_cnt_r[k] <= lo_cnt_nxt[k];
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/icca_queue.sv =====
`default_nettype none
module icca_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire icca_pkg::job_t push_job,
  input  wire logic           pop,
  output icca_pkg::job_t      head_job,
  output logic                empty,
  output logic                full
);
`include "assert_macros.svh"

  icca_pkg::job_t                entry_r[icca_pkg::QUEUE_DEPTH];
  logic [icca_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [icca_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [icca_pkg::QPTR_W:0]     count_r;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (icca_pkg::QPTR_W + 1)'(icca_pkg::QUEUE_DEPTH));
  assign head_job = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + (icca_pkg::QPTR_W)'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + (icca_pkg::QPTR_W)'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (icca_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (icca_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  `ICCA_ASSERT_IMP(a_no_push_full, push, !full)
  `ICCA_ASSERT_IMP(a_no_pop_empty, pop, !empty)

endmodule
`default_nettype wire

// ===== hw/rtl/icca_back.sv =====
`default_nettype none
module icca_back #(
  parameter int TARGET_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire icca_pkg::job_t                   head_job,
  input  wire logic                             q_empty,
  output logic                                  pop,
  output logic                                  store_busy,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_interlaced,
  output logic [icca_pkg::WEIGHT_W-1:0]         out_target_total
);
`include "assert_macros.svh"

  localparam int AW = (TARGET_DEPTH > 1) ? $clog2(TARGET_DEPTH) : 1;

  logic [icca_pkg::WEIGHT_W-1:0] mem[TARGET_DEPTH];

  logic                          clr_busy_r;
  logic [AW-1:0]                 clr_cnt_r;

  logic                          s1_valid_r;
  logic                          s1_ok_r;
  logic                          s1_inr_r;
  logic [AW-1:0]                 s1_addr_r;
  logic [icca_pkg::WEIGHT_W-1:0] s1_weight_r;
  logic [icca_pkg::WEIGHT_W-1:0] rdata_r;
  logic                          fwd_hit_r;
  logic [icca_pkg::WEIGHT_W-1:0] fwd_data_r;

  logic                          out_valid_r;
  logic                          out_interlaced_r;
  logic [icca_pkg::WEIGHT_W-1:0] out_total_r;

  logic [31:0]                   head_ext;
  logic [AW-1:0]                 head_addr;
  logic [icca_pkg::WEIGHT_W-1:0] cur;
  logic [icca_pkg::WEIGHT_W-1:0] sum;
  logic [icca_pkg::WEIGHT_W-1:0] total;
  logic                          s1_fire;
  logic                          wr_en;
  logic                          fwd_hit;

  assign head_ext  = {{(32 - icca_pkg::IDX_W){1'b0}}, head_job.idx};
  assign head_addr = head_ext[AW-1:0];

  assign s1_fire = s1_valid_r & (~out_valid_r | ~out_stall);
  assign pop     = ~q_empty & ~clr_busy_r & (~s1_valid_r | s1_fire);

  // The store is written in the same cycle that the next entry is read, so a
  // back-to-back hit on the same index takes the value being written instead.
  assign cur   = fwd_hit_r ? fwd_data_r : rdata_r;
  assign sum   = cur + (s1_ok_r ? s1_weight_r : '0);
  assign total = s1_inr_r ? sum : '0;
  assign wr_en = s1_fire & s1_ok_r & s1_inr_r;
  assign fwd_hit = s1_fire & s1_inr_r & head_job.in_range & (s1_addr_r == head_addr);

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (wr_en) begin
      mem[s1_addr_r] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata_r     <= mem[head_addr];
      s1_ok_r     <= head_job.ok;
      s1_inr_r    <= head_job.in_range;
      s1_addr_r   <= head_addr;
      s1_weight_r <= head_job.weight;
      fwd_hit_r   <= fwd_hit;
      fwd_data_r  <= sum;
    end
    if (s1_fire) begin
      out_interlaced_r <= s1_ok_r;
      out_total_r      <= total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(TARGET_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (pop) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign store_busy       = clr_busy_r;
  assign out_valid        = out_valid_r;
  assign out_interlaced   = out_interlaced_r;
  assign out_target_total = out_total_r;

  `ICCA_ASSERT_NEXT(a_clear_once, !clr_busy_r, !clr_busy_r)
  `ICCA_ASSERT_IMP(a_no_write_in_clear, clr_busy_r, !wr_en && !s1_valid_r)

endmodule
`default_nettype wire

// ===== dv/interlace_verdict_checker.sv =====
module interlace_verdict_checker #(
  parameter int MAX_COLORS   = 8,
  parameter int MAX_LEVEL    = 15,
  parameter int TARGET_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [icca_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [icca_pkg::SYM_W-1:0]    in_upper_color,
  input  logic [icca_pkg::SYM_W-1:0]    in_lower_color,
  input  logic                          in_lower_present,
  input  logic                          in_last,
  input  logic [icca_pkg::IDX_W-1:0]    in_target_index,
  input  logic [icca_pkg::WEIGHT_W-1:0] in_weight,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_interlaced,
  input  logic [icca_pkg::WEIGHT_W-1:0] out_target_total,
  output int                            mismatches,
  output int                            verdicts_pending,
  output int                            verdicts_checked,
  output int                            verdicts_interlaced
);

  typedef struct {
    logic                          interlaced;
    logic [icca_pkg::WEIGHT_W-1:0] total;
  } verdict_t;

  verdict_t                      expected_verdicts[$];
  logic [icca_pkg::CNT_W-1:0]    upper_seen[MAX_COLORS];
  logic [icca_pkg::CNT_W-1:0]    lower_seen[MAX_COLORS];
  logic                          pair_broken;
  logic [icca_pkg::WEIGHT_W-1:0] count_store[TARGET_DEPTH];
  logic [icca_pkg::CFG_W-1:0]    colors_cfg;
  logic [icca_pkg::CFG_W-1:0]    level_cfg;
  int                            mismatch_tally = 0;
  int                            checked_tally = 0;
  int                            interlaced_tally = 0;

  task automatic clear_pair();
    for (int c = 0; c < MAX_COLORS; c++) begin
      upper_seen[c] = '0;
      lower_seen[c] = '0;
    end
    pair_broken = 1'b0;
  endtask

  // Advances the per-color counters by one accepted position and, on the final
  // position of a pair, queues the verdict and the new store total.
  task automatic predict_position();
    int                            n;
    int                            lv;
    int                            c;
    logic                          ok;
    logic [icca_pkg::WEIGHT_W-1:0] total;
    verdict_t                      v;
    n = (colors_cfg > MAX_COLORS) ? MAX_COLORS : int'(colors_cfg);
    if (in_upper_color >= 1 && in_upper_color <= n) begin
      c = int'(in_upper_color) - 1;
      if (upper_seen[c] != lower_seen[c]) pair_broken = 1'b1;
      if (upper_seen[c] != '1) upper_seen[c] = upper_seen[c] + 1'b1;
    end
    if (in_lower_present && in_lower_color >= 1 && in_lower_color <= n) begin
      c = int'(in_lower_color) - 1;
      if (int'(lower_seen[c]) + 1 != int'(upper_seen[c])) pair_broken = 1'b1;
      if (lower_seen[c] != '1) lower_seen[c] = lower_seen[c] + 1'b1;
    end
    if (in_last) begin
      lv = (level_cfg > MAX_LEVEL) ? MAX_LEVEL : int'(level_cfg);
      ok = !pair_broken;
      for (c = 0; c < n; c++) begin
        if (int'(lower_seen[c]) != lv || int'(upper_seen[c]) != lv + 1) ok = 1'b0;
      end
      total = '0;
      if (int'(in_target_index) < TARGET_DEPTH) begin
        if (ok) count_store[in_target_index] = count_store[in_target_index] + in_weight;
        total = count_store[in_target_index];
      end
      v.interlaced = ok;
      v.total      = total;
      expected_verdicts = {expected_verdicts, v};
      clear_pair();
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst_n) begin
      clear_pair();
      foreach (count_store[i]) count_store[i] = '0;
      colors_cfg = icca_pkg::NUM_COLORS_RST;
      level_cfg  = icca_pkg::LEVEL_RST;
      expected_verdicts.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          $error("Verdict with none outstanding: interlaced %0b, target_total %0h.",
                 out_interlaced, out_target_total);
          mismatch_tally++;
        end else begin
          want = expected_verdicts.pop_front();
          checked_tally++;
          if (want.interlaced) interlaced_tally++;
          if (out_interlaced !== want.interlaced) begin
            $error("interlaced: expected %0b, actual %0b", want.interlaced, out_interlaced);
            mismatch_tally++;
          end
          if (out_target_total !== want.total) begin
            $error("target_total: expected %0h, actual %0h", want.total, out_target_total);
            mismatch_tally++;
          end
        end
      end
      // A position accepted at the same edge as a register write still sees the
      // old register value.
      if (in_valid && !in_stall) predict_position();
      if (cfg_we) begin
        if (cfg_index == icca_pkg::CFG_NUM_COLORS) colors_cfg = cfg_wdata;
        else level_cfg = cfg_wdata;
      end
    end
    mismatches          <= mismatch_tally;
    verdicts_pending    <= expected_verdicts.size();
    verdicts_checked    <= checked_tally;
    verdicts_interlaced <= interlaced_tally;
  end

endmodule

// ===== dv/interlacing_check_count_accumulator_top_tb.sv =====
module interlacing_check_count_accumulator_top_tb;

  localparam int MAX_COLORS   = 8;
  localparam int MAX_LEVEL    = 15;
  localparam int TARGET_DEPTH = 1024;
  // The limit must also cover the quiet clearing pass that follows reset.
  localparam int QUIET_LIMIT  = 4000;
  localparam int LONG_HOLD    = 80;

  typedef struct {
    logic [icca_pkg::SYM_W-1:0]    upper_color;
    logic [icca_pkg::SYM_W-1:0]    lower_color;
    logic                          lower_present;
    logic                          last;
    logic [icca_pkg::IDX_W-1:0]    target_index;
    logic [icca_pkg::WEIGHT_W-1:0] weight;
  } position_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic                          cfg_index = 1'b0;
  logic [icca_pkg::CFG_W-1:0]    cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [icca_pkg::SYM_W-1:0]    in_upper_color = '0;
  logic [icca_pkg::SYM_W-1:0]    in_lower_color = '0;
  logic                          in_lower_present = 1'b0;
  logic                          in_last = 1'b0;
  logic [icca_pkg::IDX_W-1:0]    in_target_index = '0;
  logic [icca_pkg::WEIGHT_W-1:0] in_weight = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_interlaced;
  logic [icca_pkg::WEIGHT_W-1:0] out_target_total;

  int        mismatches;
  int        verdicts_pending;
  int        verdicts_checked;
  int        verdicts_interlaced;
  int        positions_sent = 0;
  int        settings_used = 0;
  int        quiet_cycles = 0;
  bit        tx_calm = 1'b0;
  bit        hold_req = 1'b0;
  position_t pair_q[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  interlacing_check_count_accumulator_top dut (.*);

  interlace_verdict_checker #(
    .MAX_COLORS  (MAX_COLORS),
    .MAX_LEVEL   (MAX_LEVEL),
    .TARGET_DEPTH(TARGET_DEPTH)
  ) u_checker (.*);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles.", QUIET_LIMIT);
      $display("interlacing_check_count_accumulator_top: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stalls per transaction, calm stretches, and long
  // hold-offs that back the block up into its input.
  initial begin
    int gap;
    int taken;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    forever begin
      if (taken == 25 || taken == 80 || hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if ($urandom_range(0, 15) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  function automatic logic [icca_pkg::SYM_W-1:0] foreign_symbol(input int n);
    if (n >= 15 || $urandom_range(0, 2) == 0) return '0;
    return icca_pkg::SYM_W'($urandom_range(n + 1, 15));
  endfunction

  task automatic send_position(input position_t p);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_upper_color   <= p.upper_color;
    in_lower_color   <= p.lower_color;
    in_lower_present <= p.lower_present;
    in_last          <= p.last;
    in_target_index  <= p.target_index;
    in_weight        <= p.weight;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    positions_sent++;
  endtask

  task automatic offer(input logic [icca_pkg::SYM_W-1:0] up,
                       input logic [icca_pkg::SYM_W-1:0] lo,
                       input logic pres, input logic fin,
                       input logic [icca_pkg::IDX_W-1:0] idx,
                       input logic [icca_pkg::WEIGHT_W-1:0] w);
    position_t p;
    p.upper_color   = up;
    p.lower_color   = lo;
    p.lower_present = pres;
    p.last          = fin;
    p.target_index  = idx;
    p.weight        = w;
    send_position(p);
  endtask

  // Lets every outstanding verdict come back, then idles before the caller goes on.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input int nc, input int lv);
    cfg_we    <= 1'b1;
    cfg_index <= icca_pkg::CFG_NUM_COLORS;
    cfg_wdata <= icca_pkg::CFG_W'(nc);
    @(posedge clk);
    cfg_index <= icca_pkg::CFG_LEVEL;
    cfg_wdata <= icca_pkg::CFG_W'(lv);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Builds word pairs from per-color chains that alternate upper and lower
  // occurrences, shuffled together and padded with ignored symbols. Some
  // pairs are then damaged so that they may fail.
  task automatic run_pairs(input int nc, input int lv, input int count);
    int        n;
    int        left[MAX_COLORS];
    bit        next_up[MAX_COLORS];
    int        ev_color[$];
    bit        ev_upper[$];
    int        pick;
    int        i;
    int        k;
    position_t p;
    drain();
    configure(nc, lv);
    n = (nc > MAX_COLORS) ? MAX_COLORS : nc;
    repeat (count) begin
      pair_q.delete();
      ev_color.delete();
      ev_upper.delete();
      for (int c = 0; c < n; c++) begin
        left[c]    = 2 * lv + 1;
        next_up[c] = 1'b1;
      end
      repeat (n * (2 * lv + 1)) begin
        pick = $urandom_range(0, n - 1);
        while (left[pick] == 0) pick = (pick + 1) % n;
        ev_color = {ev_color, pick + 1};
        ev_upper = {ev_upper, next_up[pick]};
        next_up[pick] = !next_up[pick];
        left[pick]--;
      end
      i = 0;
      while (i < ev_color.size() || pair_q.size() == 0) begin
        p.upper_color   = foreign_symbol(n);
        p.lower_present = $urandom_range(0, 1);
        p.lower_color   = p.lower_present ? foreign_symbol(n)
                                          : icca_pkg::SYM_W'($urandom_range(0, 15));
        p.last          = 1'b0;
        p.target_index  = ($urandom_range(0, 3) != 0)
                          ? icca_pkg::IDX_W'($urandom_range(0, 7))
                          : icca_pkg::IDX_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 2))
          0: p.weight = {$urandom, $urandom};
          1: p.weight = {32'hffff_ffff, $urandom};
          default: p.weight = icca_pkg::WEIGHT_W'($urandom_range(0, 255));
        endcase
        if (i < ev_color.size() && $urandom_range(0, 7) != 0) begin
          if (ev_upper[i]) begin
            p.upper_color = icca_pkg::SYM_W'(ev_color[i]);
            i++;
          end
          if (i < ev_color.size() && !ev_upper[i] && $urandom_range(0, 3) != 0) begin
            p.lower_color   = icca_pkg::SYM_W'(ev_color[i]);
            p.lower_present = 1'b1;
            i++;
          end
        end
        pair_q = {pair_q, p};
      end
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(0, pair_q.size() - 1);
        case ($urandom_range(0, 3))
          0: pair_q[k].upper_color = icca_pkg::SYM_W'($urandom_range(0, 15));
          1: begin
            pair_q[k].lower_present = !pair_q[k].lower_present;
            pair_q[k].lower_color   = icca_pkg::SYM_W'($urandom_range(0, 15));
          end
          2: if (pair_q.size() > 1) pair_q.delete(k);
          default: if (k + 1 < pair_q.size()) begin
            p             = pair_q[k];
            pair_q[k]     = pair_q[k + 1];
            pair_q[k + 1] = p;
          end
        endcase
      end
      foreach (pair_q[j]) pair_q[j].last = 1'b0;
      pair_q[pair_q.size() - 1].last = 1'b1;
      foreach (pair_q[j]) send_position(pair_q[j]);
    end
  endtask

  initial begin
    int nc;
    int lv;
    int pairs;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: two colors, level one. A clean pair loads all ones.
    offer(1, 0, 0, 0, '1, '1);
    offer(2, 1, 1, 0, 5, 64'h1234);
    offer(1, 2, 1, 0, 0, 0);
    offer(2, 0, 0, 1, 1023, '1);
    // Ignored symbols in front, then the same pair again; the entry wraps to zero.
    offer(0, 15, 0, 0, 1023, '1);
    offer(15, 3, 1, 0, 0, 0);
    offer(1, 0, 0, 0, $urandom, {$urandom, $urandom});
    offer(2, 1, 1, 0, $urandom, {$urandom, $urandom});
    offer(1, 2, 1, 0, $urandom, {$urandom, $urandom});
    offer(2, 0, 0, 1, 1023, 64'd1);
    // A lower occurrence ahead of its upper one fails and leaves the store alone.
    offer(2, 1, 1, 0, 0, 0);
    offer(1, 2, 1, 0, 0, 0);
    offer(2, 0, 0, 1, 0, 64'd5);

    // With no colors every pair interlaces.
    drain();
    configure(0, 0);
    offer(7, 9, 1, 1, 3, 64'd77);
    // One-position pairs back to back while the result side holds off, so the
    // queue fills and the input stalls; shared indexes exercise forwarding.
    hold_req = 1'b1;
    tx_calm  = 1'b1;
    repeat (24) offer(0, 0, 0, 1, icca_pkg::IDX_W'($urandom_range(0, 3)),
                      {$urandom, $urandom});
    tx_calm  = 1'b0;
    // Level zero expects a single upper occurrence per color.
    drain();
    configure(1, 0);
    offer(1, 0, 0, 1, 3, 64'd1);
    // A color count above the maximum acts as the maximum.
    drain();
    configure(15, 0);
    for (int c = 1; c <= MAX_COLORS; c++) begin
      offer(icca_pkg::SYM_W'(c), 15, 1, c == MAX_COLORS, 1023, 64'd2);
    end
    // Registers change in the middle of a pair; color two turns foreign.
    drain();
    configure(2, 1);
    offer(1, 0, 0, 0, 0, 0);
    offer(2, 1, 1, 0, 0, 0);
    drain();
    configure(1, 1);
    offer(1, 2, 1, 1, 4, 64'd9);

    // Counters run into saturation; the pair must fail.
    drain();
    configure(1, 15);
    tx_calm = 1'b1;
    repeat (269) offer(1, 1, 1, 0, $urandom, {$urandom, $urandom});
    offer(1, 1, 1, 1, 6, 64'd3);
    tx_calm = 1'b0;

    run_pairs(8, 15, 1);
    run_pairs(15, 2, 2);
    run_pairs(0, 9, 3);
    run_pairs(1, 1, 4);
    while (positions_sent < 720) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0: nc = 0;
          1: nc = 1;
          2: nc = MAX_COLORS;
          default: nc = 15;
        endcase
      end else begin
        nc = $urandom_range(1, 4);
      end
      lv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
      pairs = (lv > 3 && nc > 2) ? 1 : $urandom_range(2, 8);
      tx_calm = ($urandom_range(0, 3) == 0);
      run_pairs(nc, lv, pairs);
    end

    drain();
    repeat (6) @(posedge clk);
    $display("Sent %0d positions under %0d register settings, with saturated counters,",
             positions_sent, settings_used);
    $display("a mid-pair register change and %0d verdicts checked (%0d interlaced).",
             verdicts_checked, verdicts_interlaced);
    if (mismatches == 0 && verdicts_pending == 0) begin
      $display("interlacing_check_count_accumulator_top: match");
    end else begin
      $display("interlacing_check_count_accumulator_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/icca_pkg.sv
hw/rtl/icca_front.sv
hw/rtl/icca_queue.sv
hw/rtl/icca_back.sv
hw/rtl/interlacing_check_count_accumulator_top.sv
dv/interlace_verdict_checker.sv
dv/interlacing_check_count_accumulator_top_tb.sv
